[rtl/rcuc_pkg.sv]
// Shared types, constants and helpers of the undershoot correction unit.
package rcuc_pkg;

	// Field and datapath widths
	localparam int SAMPLE_BITS     = 14;
	localparam int COEFF_BITS      = 16;
	localparam int COEFF_FRAC_BITS = 16;
	localparam int OUT_BITS        = 20;
	localparam int DIFF_BITS       = SAMPLE_BITS + 1;
	localparam int CAP_BITS        = OUT_BITS + COEFF_FRAC_BITS;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 16;

	// Queue sizing, used by the job queue and the result queue
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS = Q_PTR_BITS + 1;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PEDESTAL  = 2'd0,
		REG_CHARGE    = 2'd1,
		REG_DISCHARGE = 2'd2
	} reg_index_t;

	// Configuration register set
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] pedestal;
		logic [COEFF_BITS-1:0]  charge_coeff;
		logic [COEFF_BITS-1:0]  discharge_coeff;
	} cfg_t;

	// One classified sample handed from the front end to the back end
	typedef struct packed {
		logic signed [DIFF_BITS-1:0] diff;
		logic [COEFF_BITS-1:0]       coeff;
		logic                        first;
	} job_t;

	// Saturate a value one bit wider than the output to the output range.
	function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [OUT_BITS:0] v);
		logic signed [OUT_BITS-1:0] res;
		if (v[OUT_BITS] == v[OUT_BITS-1]) begin
			res = v[OUT_BITS-1:0];
		end else if (v[OUT_BITS]) begin
			res = {1'b1, {(OUT_BITS-1){1'b0}}};
		end else begin
			res = {1'b0, {(OUT_BITS-1){1'b1}}};
		end
		return res;
	endfunction

endpackage

[rtl/rc_coupling_undershoot_correction_unit.sv]
// Top level of the AC-coupling undershoot correction unit.
//
//  channel   handshake             payload
//  input     push / full           raw_sample, first_sample
//  result    pop / empty           corrected_sample
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample is taken every cycle while full is low; the capacitor recurrence closes
// through the state registers cap_q and pc_q, with one multiply-add on the loop.
// A taken beat passes the job queue, stage one and the result queue to its result.
// Reset zeroes the recurrence state, the queue pointers and counts and cfg_q.
// A stalled result side fills the result queue, then the job queue, then raises full.
module rc_coupling_undershoot_correction_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  logic [rcuc_pkg::SAMPLE_BITS-1:0]        raw_sample,
	input  logic                                    first_sample,
	input  logic                                    pop,
	output logic                                    empty,
	output logic signed [rcuc_pkg::OUT_BITS-1:0]    corrected_sample,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [rcuc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [rcuc_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
	import rcuc_pkg::*;

	cfg_t cfg_q;
	job_t front_job;
	job_t back_job;
	logic job_push;
	logic job_pop;
	logic job_empty;

	// Configuration registers accept a beat every cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PEDESTAL:  cfg_q.pedestal        <= cfg_data[SAMPLE_BITS-1:0];
				REG_CHARGE:    cfg_q.charge_coeff    <= cfg_data[COEFF_BITS-1:0];
				REG_DISCHARGE: cfg_q.discharge_coeff <= cfg_data[COEFF_BITS-1:0];
				default:       cfg_q                 <= cfg_q;
			endcase
		end
	end

	rcuc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.raw_sample   (raw_sample),
		.first_sample (first_sample),
		.cfg          (cfg_q),
		.job_push     (job_push),
		.job          (front_job)
	);

	rcuc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (front_job),
		.full     (full),
		.pop      (job_pop),
		.pop_job  (back_job),
		.empty    (job_empty)
	);

	rcuc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.job              (back_job),
		.job_empty        (job_empty),
		.job_pop          (job_pop),
		.pedestal         (cfg_q.pedestal),
		.pop              (pop),
		.empty            (empty),
		.corrected_sample (corrected_sample)
	);

endmodule

[rtl/rcuc_queue.sv]
// Short job queue between the front end and the back end.
module rcuc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rcuc_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output rcuc_pkg::job_t pop_job,
	output logic          empty
);
	import rcuc_pkg::*;

	job_t                  mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_CNT_BITS-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (cnt_q == Q_CNT_BITS'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage needs no reset
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

endmodule

[rtl/rcuc_front.sv]
// Front end: takes raw samples, removes the pedestal and picks the time constant.
module rcuc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic                             full,
	input  logic [rcuc_pkg::SAMPLE_BITS-1:0] raw_sample,
	input  logic                             first_sample,
	input  rcuc_pkg::cfg_t                   cfg,
	output logic                             job_push,
	output rcuc_pkg::job_t                   job
);
	import rcuc_pkg::*;

	logic signed [DIFF_BITS-1:0] prev_raw_q;
	logic signed [DIFF_BITS-1:0] diff;
	logic                        falling;

	// Pedestal-subtracted sample and the falling-edge test
	assign diff     = $signed({1'b0, raw_sample}) - $signed({1'b0, cfg.pedestal});
	assign falling  = (diff < prev_raw_q);
	assign job_push = push && !full;

	always_comb begin
		job.diff  = diff;
		job.coeff = falling ? cfg.charge_coeff : cfg.discharge_coeff;
		job.first = first_sample;
	end

	// The previous difference is kept for every accepted beat, first ones included
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q <= '0;
		end else if (job_push) begin
			prev_raw_q <= diff;
		end
	end

endmodule

[rtl/rcuc_back.sv]
// Back end: capacitor recurrence, pedestal restore and result queue.
module rcuc_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rcuc_pkg::job_t                       job,
	input  logic                                 job_empty,
	output logic                                 job_pop,
	input  logic [rcuc_pkg::SAMPLE_BITS-1:0]     pedestal,
	input  logic                                 pop,
	output logic                                 empty,
	output logic signed [rcuc_pkg::OUT_BITS-1:0] corrected_sample
);
	import rcuc_pkg::*;

	localparam int FRAC       = COEFF_FRAC_BITS;
	localparam int HI_BITS    = OUT_BITS + 2;
	localparam int PHI_BITS   = COEFF_BITS + 1 + HI_BITS;
	localparam int LOP_BITS   = COEFF_BITS + FRAC;
	localparam int NEXT_BITS  = PHI_BITS + 2;

	// Recurrence state
	logic signed [CAP_BITS-1:0] cap_q;
	logic signed [OUT_BITS-1:0] pc_q;

	// Stage towards the result queue
	logic                       valid_s1;
	logic signed [OUT_BITS-1:0] pc_s1;

	// Result queue
	logic signed [OUT_BITS-1:0] out_mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0]      out_wr_q;
	logic [Q_PTR_BITS-1:0]      out_rd_q;
	logic [Q_CNT_BITS-1:0]      out_cnt_q;
	logic                       out_pop;

	logic                        fire;
	logic signed [OUT_BITS-1:0]  cap_hi;
	logic [FRAC-1:0]             cap_lo;
	logic signed [HI_BITS-1:0]   gap_hi;
	logic [FRAC-1:0]             gap_lo;
	logic signed [PHI_BITS-1:0]  prod_hi;
	logic [LOP_BITS-1:0]         prod_lo;
	logic signed [NEXT_BITS-1:0] delta;
	logic signed [NEXT_BITS-1:0] cap_next;
	logic signed [CAP_BITS-1:0]  cap_sat;
	logic signed [OUT_BITS-1:0]  cap_int;
	logic signed [OUT_BITS:0]    corr_sum;
	logic signed [OUT_BITS-1:0]  pc_new;
	logic signed [OUT_BITS:0]    out_sum;

	// A job runs only when the result queue has room for it and the beat in flight
	assign fire    = !job_empty &&
			(({1'b0, out_cnt_q} + {{Q_CNT_BITS{1'b0}}, valid_s1}) < (Q_CNT_BITS+1)'(Q_DEPTH));
	assign job_pop = fire;

	// Gap to the target, split into a signed high part and an unsigned fraction
	assign cap_hi = cap_q[CAP_BITS-1 -: OUT_BITS];
	assign cap_lo = cap_q[FRAC-1:0];
	assign gap_hi = {{2{pc_q[OUT_BITS-1]}}, pc_q} - {{2{cap_hi[OUT_BITS-1]}}, cap_hi}
			- {{(HI_BITS-1){1'b0}}, (cap_lo != '0)};
	assign gap_lo = ~cap_lo + {{(FRAC-1){1'b0}}, 1'b1};

	// Coefficient times the gap, floored to the fraction width
	assign prod_hi = $signed({1'b0, job.coeff}) * gap_hi;
	assign prod_lo = job.coeff * gap_lo;
	assign delta   = {{(NEXT_BITS-PHI_BITS){prod_hi[PHI_BITS-1]}}, prod_hi}
			+ {{(NEXT_BITS-COEFF_BITS){1'b0}}, prod_lo[LOP_BITS-1 -: COEFF_BITS]};
	assign cap_next = {{(NEXT_BITS-CAP_BITS){cap_q[CAP_BITS-1]}}, cap_q} + delta;

	// Saturate the new level to the capacitor range
	always_comb begin
		priority if (!cap_next[NEXT_BITS-1] && (|cap_next[NEXT_BITS-2:CAP_BITS-1])) begin
			cap_sat = {1'b0, {(CAP_BITS-1){1'b1}}};
		end else if (cap_next[NEXT_BITS-1] && !(&cap_next[NEXT_BITS-2:CAP_BITS-1])) begin
			cap_sat = {1'b1, {(CAP_BITS-1){1'b0}}};
		end else begin
			cap_sat = cap_next[CAP_BITS-1:0];
		end
	end

	// Integer part of the level plus the new difference
	assign cap_int  = cap_sat[CAP_BITS-1 -: OUT_BITS];
	assign corr_sum = {cap_int[OUT_BITS-1], cap_int}
			+ {{(OUT_BITS+1-DIFF_BITS){job.diff[DIFF_BITS-1]}}, job.diff};
	assign pc_new   = sat_out(corr_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
			pc_q  <= '0;
		end else if (fire) begin
			if (job.first) begin
				cap_q <= '0;
				pc_q  <= '0;
			end else begin
				cap_q <= cap_sat;
				pc_q  <= pc_new;
			end
		end
	end

	// Stage one holds the corrected value for the pedestal restore
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) pc_s1 <= job.first ? '0 : pc_new;
	end

	assign out_sum = {pc_s1[OUT_BITS-1], pc_s1}
			+ $signed({{(OUT_BITS+1-SAMPLE_BITS){1'b0}}, pedestal});

	// Result queue control
	assign empty            = (out_cnt_q == '0);
	assign out_pop          = pop && !empty;
	assign corrected_sample = out_mem_q[out_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (valid_s1) out_wr_q <= out_wr_q + 1'b1;
			if (out_pop)  out_rd_q <= out_rd_q + 1'b1;
			if (valid_s1 && !out_pop) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (out_pop && !valid_s1) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) out_mem_q[out_wr_q] <= sat_out(out_sum);
	end

	// A first-sample beat restarts the recurrence from zero
	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && job.first |=> (cap_q == '0) && (pc_q == '0))
		else $error("recurrence state not cleared by first sample");

	// Every job that runs reaches stage one in the next cycle
	a_fire_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s1)
		else $error("job lost between recurrence and stage one");

	// A beat in stage one always finds room in the result queue
	a_s1_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (out_cnt_q < Q_CNT_BITS'(Q_DEPTH)))
		else $error("result queue overrun");

	// The fill count never passes the depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= Q_CNT_BITS'(Q_DEPTH))
		else $error("result queue count out of range");

endmodule
